// ===== src/char_lcd_nibble_port_sequencer_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef CHAR_LCD_NIBBLE_PORT_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_PORT_SEQUENCER_MACROS_SVH

// same-cycle implication, held off during reset
`define CLNPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define CLNPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/clnps_pkg.sv =====
package clnps_pkg;

  localparam int unsigned COLUMNS = 16;
  localparam int unsigned ROWS    = 2;

  localparam int unsigned PC_W = 6;

  localparam logic [2:0] CMD_INSTR     = 3'd0;
  localparam logic [2:0] CMD_CHAR      = 3'd1;
  localparam logic [2:0] CMD_CURSOR    = 3'd2;
  localparam logic [2:0] CMD_CLEAR     = 3'd3;
  localparam logic [2:0] CMD_INIT      = 3'd4;
  localparam logic [2:0] CMD_BACKLIGHT = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;

  localparam logic [PC_W-1:0] PC_BYTE  = 6'd0;
  localparam logic [PC_W-1:0] PC_CLEAR = 6'd6;
  localparam logic [PC_W-1:0] PC_INIT  = 6'd12;
  localparam logic [PC_W-1:0] PC_BL    = 6'd55;
  localparam logic [PC_W-1:0] PC_MAX   = 6'd55;

  localparam logic [1:0] NS_HI    = 2'd0;
  localparam logic [1:0] NS_LO    = 2'd1;
  localparam logic [1:0] NS_CONST = 2'd2;

  localparam logic [2:0] W_0    = 3'd0;
  localparam logic [2:0] W_5    = 3'd1;
  localparam logic [2:0] W_100  = 3'd2;
  localparam logic [2:0] W_300  = 3'd3;
  localparam logic [2:0] W_2600 = 3'd4;
  localparam logic [2:0] W_5100 = 3'd5;
  localparam logic [2:0] W_100K = 3'd6;

  typedef struct packed {
    logic [1:0] nib_sel;
    logic [3:0] nib_const;
    logic       en;
    logic [2:0] wait_sel;
    logic       last;
    logic       set_init;
  } ucode_t;

  function automatic ucode_t uw(input logic [1:0] sel, input logic [3:0] nib,
                                input logic en, input logic [2:0] ws,
                                input logic last, input logic set_init);
    ucode_t w;
    w.nib_sel   = sel;
    w.nib_const = nib;
    w.en        = en;
    w.wait_sel  = ws;
    w.last      = last;
    w.set_init  = set_init;
    return w;
  endfunction

  function automatic logic [16:0] wait_lut(input logic [2:0] ws);
    logic [16:0] w;
    unique case (ws)
      W_0:     w = 17'd0;
      W_5:     w = 17'd5;
      W_100:   w = 17'd100;
      W_300:   w = 17'd300;
      W_2600:  w = 17'd2600;
      W_5100:  w = 17'd5100;
      W_100K:  w = 17'd100000;
      default: w = 17'd0;
    endcase
    return w;
  endfunction

  function automatic ucode_t rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      // byte from register
      6'd0:  w = uw(NS_HI, 4'h0, 1'b0, W_0,   1'b0, 1'b0);
      6'd1:  w = uw(NS_HI, 4'h0, 1'b1, W_5,   1'b0, 1'b0);
      6'd2:  w = uw(NS_HI, 4'h0, 1'b0, W_100, 1'b0, 1'b0);
      6'd3:  w = uw(NS_LO, 4'h0, 1'b0, W_0,   1'b0, 1'b0);
      6'd4:  w = uw(NS_LO, 4'h0, 1'b1, W_5,   1'b0, 1'b0);
      6'd5:  w = uw(NS_LO, 4'h0, 1'b0, W_100, 1'b1, 1'b0);
      // clear
      6'd6:  w = uw(NS_CONST, 4'h0, 1'b0, W_0,    1'b0, 1'b0);
      6'd7:  w = uw(NS_CONST, 4'h0, 1'b1, W_5,    1'b0, 1'b0);
      6'd8:  w = uw(NS_CONST, 4'h0, 1'b0, W_100,  1'b0, 1'b0);
      6'd9:  w = uw(NS_CONST, 4'h1, 1'b0, W_0,    1'b0, 1'b0);
      6'd10: w = uw(NS_CONST, 4'h1, 1'b1, W_5,    1'b0, 1'b0);
      6'd11: w = uw(NS_CONST, 4'h1, 1'b0, W_2600, 1'b1, 1'b0);
      // initialise: power-up wait
      6'd12: w = uw(NS_CONST, 4'h0, 1'b0, W_100K, 1'b0, 1'b0);
      // wake-up nibbles
      6'd13: w = uw(NS_CONST, 4'h3, 1'b0, W_0,    1'b0, 1'b0);
      6'd14: w = uw(NS_CONST, 4'h3, 1'b1, W_5,    1'b0, 1'b0);
      6'd15: w = uw(NS_CONST, 4'h3, 1'b0, W_5100, 1'b0, 1'b0);
      6'd16: w = uw(NS_CONST, 4'h3, 1'b0, W_0,    1'b0, 1'b0);
      6'd17: w = uw(NS_CONST, 4'h3, 1'b1, W_5,    1'b0, 1'b0);
      6'd18: w = uw(NS_CONST, 4'h3, 1'b0, W_300,  1'b0, 1'b0);
      6'd19: w = uw(NS_CONST, 4'h3, 1'b0, W_0,    1'b0, 1'b0);
      6'd20: w = uw(NS_CONST, 4'h3, 1'b1, W_5,    1'b0, 1'b0);
      6'd21: w = uw(NS_CONST, 4'h3, 1'b0, W_300,  1'b0, 1'b0);
      6'd22: w = uw(NS_CONST, 4'h2, 1'b0, W_0,    1'b0, 1'b0);
      6'd23: w = uw(NS_CONST, 4'h2, 1'b1, W_5,    1'b0, 1'b0);
      6'd24: w = uw(NS_CONST, 4'h2, 1'b0, W_300,  1'b0, 1'b0);
      // function set 0x28
      6'd25: w = uw(NS_CONST, 4'h2, 1'b0, W_0,    1'b0, 1'b0);
      6'd26: w = uw(NS_CONST, 4'h2, 1'b1, W_5,    1'b0, 1'b0);
      6'd27: w = uw(NS_CONST, 4'h2, 1'b0, W_100,  1'b0, 1'b0);
      6'd28: w = uw(NS_CONST, 4'h8, 1'b0, W_0,    1'b0, 1'b0);
      6'd29: w = uw(NS_CONST, 4'h8, 1'b1, W_5,    1'b0, 1'b0);
      6'd30: w = uw(NS_CONST, 4'h8, 1'b0, W_100,  1'b0, 1'b0);
      // display off 0x08
      6'd31: w = uw(NS_CONST, 4'h0, 1'b0, W_0,    1'b0, 1'b0);
      6'd32: w = uw(NS_CONST, 4'h0, 1'b1, W_5,    1'b0, 1'b0);
      6'd33: w = uw(NS_CONST, 4'h0, 1'b0, W_100,  1'b0, 1'b0);
      6'd34: w = uw(NS_CONST, 4'h8, 1'b0, W_0,    1'b0, 1'b0);
      6'd35: w = uw(NS_CONST, 4'h8, 1'b1, W_5,    1'b0, 1'b0);
      6'd36: w = uw(NS_CONST, 4'h8, 1'b0, W_100,  1'b0, 1'b0);
      // clear 0x01
      6'd37: w = uw(NS_CONST, 4'h0, 1'b0, W_0,    1'b0, 1'b0);
      6'd38: w = uw(NS_CONST, 4'h0, 1'b1, W_5,    1'b0, 1'b0);
      6'd39: w = uw(NS_CONST, 4'h0, 1'b0, W_100,  1'b0, 1'b0);
      6'd40: w = uw(NS_CONST, 4'h1, 1'b0, W_0,    1'b0, 1'b0);
      6'd41: w = uw(NS_CONST, 4'h1, 1'b1, W_5,    1'b0, 1'b0);
      6'd42: w = uw(NS_CONST, 4'h1, 1'b0, W_2600, 1'b0, 1'b0);
      // entry mode 0x06
      6'd43: w = uw(NS_CONST, 4'h0, 1'b0, W_0,    1'b0, 1'b0);
      6'd44: w = uw(NS_CONST, 4'h0, 1'b1, W_5,    1'b0, 1'b0);
      6'd45: w = uw(NS_CONST, 4'h0, 1'b0, W_100,  1'b0, 1'b0);
      6'd46: w = uw(NS_CONST, 4'h6, 1'b0, W_0,    1'b0, 1'b0);
      6'd47: w = uw(NS_CONST, 4'h6, 1'b1, W_5,    1'b0, 1'b0);
      6'd48: w = uw(NS_CONST, 4'h6, 1'b0, W_100,  1'b0, 1'b0);
      // display on 0x0C
      6'd49: w = uw(NS_CONST, 4'h0, 1'b0, W_0,    1'b0, 1'b0);
      6'd50: w = uw(NS_CONST, 4'h0, 1'b1, W_5,    1'b0, 1'b0);
      6'd51: w = uw(NS_CONST, 4'h0, 1'b0, W_100,  1'b0, 1'b0);
      6'd52: w = uw(NS_CONST, 4'hC, 1'b0, W_0,    1'b0, 1'b0);
      6'd53: w = uw(NS_CONST, 4'hC, 1'b1, W_5,    1'b0, 1'b0);
      6'd54: w = uw(NS_CONST, 4'hC, 1'b0, W_100,  1'b1, 1'b1);
      // backlight only
      6'd55: w = uw(NS_CONST, 4'h0, 1'b0, W_0,    1'b1, 1'b0);
      default: w = uw(NS_CONST, 4'h0, 1'b0, W_0, 1'b1, 1'b0);
    endcase
    return w;
  endfunction

endpackage

// ===== src/char_lcd_nibble_port_sequencer.sv =====
// channel | handshake                | payload
// --------+--------------------------+----------------------------------------------
// in      | in_valid / in_stall      | in_cmd, in_value, in_col, in_row,
//         |                          | in_backlight_enable
// out     | out_valid / out_stall    | out_port_valid, out_port_byte, out_wait_us,
//         |                          | out_status, out_last
//
// One beat out per cycle unless out_stall holds it, from a microcode ROM stepped by a
// program counter: a byte op sends both nibbles, initialise the power-up program, and
// backlight and refusals a final beat only. The next op is taken once the last beat of
// the current one is in the output register. Reset (synchronous, rst_n low) sets
// backlight on and clears the initialised flag. out_stall holds a valid output register
// and freezes the sequencer; in_stall is high while an op is still being sequenced.
module char_lcd_nibble_port_sequencer
  import clnps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_value,
  input  logic [7:0]  in_col,
  input  logic [1:0]  in_row,
  input  logic        in_backlight_enable,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_port_valid,
  output logic [7:0]  out_port_byte,
  output logic [16:0] out_wait_us,
  output logic [1:0]  out_status,
  output logic        out_last
);

  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic            rs_r, rs_nxt;
  logic            refuse_r, refuse_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            bl_r, bl_nxt;
  logic            init_r, init_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            port_valid_r, port_valid_nxt;
  logic [7:0]      port_byte_r, port_byte_nxt;
  logic [16:0]     wait_r, wait_nxt;
  logic [1:0]      ostatus_r, ostatus_nxt;
  logic            last_r, last_nxt;

  logic            in_acc;
  logic            load;
  ucode_t          uc;
  logic [3:0]      nib;
  logic [6:0]      cur_addr;
  logic            cur_bad;

  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;
  assign load     = busy_r && (!out_valid_r || !out_stall);
  assign uc       = rom(pc_r);

  assign cur_addr = in_col[6:0] + {(in_row != 2'd0), 6'd0};
  assign cur_bad  = ({24'd0, in_col} >= COLUMNS) || ({30'd0, in_row} >= ROWS);

  always_comb begin
    unique case (uc.nib_sel)
      NS_HI:    nib = byte_r[7:4];
      NS_LO:    nib = byte_r[3:0];
      NS_CONST: nib = uc.nib_const;
      default:  nib = uc.nib_const;
    endcase
  end

  always_comb begin
    busy_nxt       = busy_r;
    pc_nxt         = pc_r;
    byte_nxt       = byte_r;
    rs_nxt         = rs_r;
    refuse_nxt     = refuse_r;
    status_nxt     = status_r;
    bl_nxt         = bl_r;
    init_nxt       = init_r;
    out_valid_nxt  = out_valid_r;
    port_valid_nxt = port_valid_r;
    port_byte_nxt  = port_byte_r;
    wait_nxt       = wait_r;
    ostatus_nxt    = ostatus_r;
    last_nxt       = last_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // step the program into the output register
    if (load) begin
      out_valid_nxt = 1'b1;
      if (refuse_r) begin
        port_valid_nxt = 1'b0;
        port_byte_nxt  = 8'd0;
        wait_nxt       = 17'd0;
        ostatus_nxt    = status_r;
        last_nxt       = 1'b1;
        busy_nxt       = 1'b0;
      end else begin
        port_valid_nxt = 1'b1;
        port_byte_nxt  = {nib, bl_r, uc.en, 1'b0, rs_r};
        wait_nxt       = wait_lut(uc.wait_sel);
        ostatus_nxt    = ST_OK;
        last_nxt       = uc.last;
        pc_nxt         = pc_r + 6'd1;
        if (uc.last) begin
          busy_nxt = 1'b0;
        end
        if (uc.set_init) begin
          init_nxt = 1'b1;
        end
      end
    end

    // dispatch a new op
    if (in_acc) begin
      busy_nxt   = 1'b1;
      refuse_nxt = 1'b0;
      status_nxt = ST_OK;
      rs_nxt     = 1'b0;
      byte_nxt   = in_value;
      pc_nxt     = PC_BYTE;
      unique case (in_cmd)
        CMD_INSTR: begin
          pc_nxt = PC_BYTE;
        end
        CMD_CHAR: begin
          rs_nxt = 1'b1;
          if (!init_r) begin
            refuse_nxt = 1'b1;
            status_nxt = ST_NOT_READY;
          end
        end
        CMD_CURSOR: begin
          byte_nxt = {1'b1, cur_addr};
          if (cur_bad) begin
            refuse_nxt = 1'b1;
            status_nxt = ST_INVALID;
          end
        end
        CMD_CLEAR: begin
          pc_nxt = PC_CLEAR;
        end
        CMD_INIT: begin
          pc_nxt = PC_INIT;
        end
        CMD_BACKLIGHT: begin
          pc_nxt = PC_BL;
          bl_nxt = in_backlight_enable;
        end
        default: begin
          refuse_nxt = 1'b1;
          status_nxt = ST_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= PC_BYTE;
      refuse_r    <= 1'b0;
      bl_r        <= 1'b1;
      init_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      refuse_r    <= refuse_nxt;
      bl_r        <= bl_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r       <= byte_nxt;
    rs_r         <= rs_nxt;
    status_r     <= status_nxt;
    port_valid_r <= port_valid_nxt;
    port_byte_r  <= port_byte_nxt;
    wait_r       <= wait_nxt;
    ostatus_r    <= ostatus_nxt;
    last_r       <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_port_valid = port_valid_r;
  assign out_port_byte  = port_byte_r;
  assign out_wait_us    = wait_r;
  assign out_status     = ostatus_r;
  assign out_last       = last_r;

`include "char_lcd_nibble_port_sequencer_macros.svh"

  `CLNPS_ASSERT_NEXT(a_accept_busy, in_acc, busy_r, "accepted op did not start sequencing")
  `CLNPS_ASSERT_NOW(a_pc_range, busy_r && !refuse_r, pc_r <= PC_MAX, "program counter out of ROM")
  `CLNPS_ASSERT_NOW(a_refuse_single, out_valid_r && !port_valid_r, last_r && ostatus_r != ST_OK,
                    "refusal beat not final or carries ok status")
  `CLNPS_ASSERT_NOW(a_write_ok, out_valid_r && port_valid_r, ostatus_r == ST_OK,
                    "port write beat carries error status")
  `CLNPS_ASSERT_NEXT(a_init_done, load && !refuse_r && uc.set_init, init_r,
                     "initialised flag not set after init sequence")

endmodule

// ===== bench/char_lcd_nibble_port_sequencer_test.sv =====
module char_lcd_nibble_port_sequencer_test;
  import clnps_pkg::*;

  localparam logic [2:0] CMD_UNKNOWN_LO = 3'd6;
  localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;

  localparam logic [7:0] FUNC_SET      = 8'h28;
  localparam logic [7:0] DISPLAY_OFF   = 8'h08;
  localparam logic [7:0] CLEAR_DISPLAY = 8'h01;
  localparam logic [7:0] ENTRY_MODE    = 8'h06;
  localparam logic [7:0] DISPLAY_ON    = 8'h0C;
  localparam logic [7:0] SET_DDRAM     = 8'h80;
  localparam logic [7:0] ROW1_BASE     = 8'h40;
  localparam logic [3:0] WAKE_NIBBLE   = 4'h3;
  localparam logic [3:0] FOUR_BIT_NIB  = 4'h2;

  localparam logic [16:0] T_PULSE    = 17'd5;
  localparam logic [16:0] T_SETTLE   = 17'd100;
  localparam logic [16:0] T_CLEAR    = 17'd2500;
  localparam logic [16:0] T_WAKE_1ST = 17'd5000;
  localparam logic [16:0] T_WAKE     = 17'd200;
  localparam logic [16:0] T_POWER_UP = 17'd100000;

  localparam int RANDOM_OPS  = 210;
  localparam int LONG_HOLD   = 500;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] value;
    logic [7:0] col;
    logic [1:0] row;
    logic       ble;
  } lcd_op_t;

  typedef struct packed {
    logic        port_valid;
    logic [7:0]  port_byte;
    logic [16:0] wait_us;
    logic [1:0]  status;
    logic        last;
  } port_write_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_cmd = CMD_INSTR;
  logic [7:0]  in_value = 8'h00;
  logic [7:0]  in_col = 8'h00;
  logic [1:0]  in_row = 2'd0;
  logic        in_backlight_enable = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_port_valid;
  logic [7:0]  out_port_byte;
  logic [16:0] out_wait_us;
  logic [1:0]  out_status;
  logic        out_last;

  lcd_op_t     op_q[$];
  port_write_t write_q[$];

  logic backlight_lit = 1'b1;
  logic lcd_ready = 1'b0;

  int beats_in = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  int cycle_count = 0;
  int fault_count = 0;
  int writes_checked = 0;
  int inits_seen = 0;
  int refusals_seen = 0;
  int cursors_seen = 0;
  int chars_seen = 0;

  wire calm = (beats_in >= 100) && (beats_in < 140);

  char_lcd_nibble_port_sequencer DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_value            (in_value),
    .in_col              (in_col),
    .in_row              (in_row),
    .in_backlight_enable (in_backlight_enable),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_port_valid      (out_port_valid),
    .out_port_byte       (out_port_byte),
    .out_wait_us         (out_wait_us),
    .out_status          (out_status),
    .out_last            (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic add_write(input logic [7:0] pins, input logic [16:0] wait_us);
    port_write_t w;
    w.port_valid = 1'b1;
    w.port_byte  = pins;
    w.wait_us    = wait_us;
    w.status     = ST_OK;
    w.last       = 1'b0;
    write_q.push_back(w);
  endtask

  task automatic add_nibble(input logic [3:0] nib, input logic rs);
    add_write({nib, backlight_lit, 1'b0, 1'b0, rs}, 17'd0);
    add_write({nib, backlight_lit, 1'b1, 1'b0, rs}, T_PULSE);
    add_write({nib, backlight_lit, 1'b0, 1'b0, rs}, T_SETTLE);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic rs);
    add_nibble(b[7:4], rs);
    add_nibble(b[3:0], rs);
  endtask

  task automatic bump_tail(input logic [16:0] extra, input logic mark_last);
    port_write_t w;
    w = write_q.pop_back();
    w.wait_us = w.wait_us + extra;
    if (mark_last) w.last = 1'b1;
    write_q.push_back(w);
  endtask

  task automatic add_refusal(input logic [1:0] status);
    port_write_t w;
    w.port_valid = 1'b0;
    w.port_byte  = 8'h00;
    w.wait_us    = 17'd0;
    w.status     = status;
    w.last       = 1'b1;
    write_q.push_back(w);
    refusals_seen++;
  endtask

  task automatic predict_port_writes(input lcd_op_t op);
    logic [7:0] addr;
    case (op.cmd)
      CMD_INSTR: begin
        add_byte(op.value, 1'b0);
        bump_tail(17'd0, 1'b1);
      end
      CMD_CHAR: begin
        if (!lcd_ready) begin
          add_refusal(ST_NOT_READY);
        end else begin
          chars_seen++;
          add_byte(op.value, 1'b1);
          bump_tail(17'd0, 1'b1);
        end
      end
      CMD_CURSOR: begin
        if (int'(op.col) >= int'(COLUMNS) || int'(op.row) >= int'(ROWS)) begin
          add_refusal(ST_INVALID);
        end else begin
          cursors_seen++;
          addr = op.col + ((op.row != 2'd0) ? ROW1_BASE : 8'h00);
          add_byte(SET_DDRAM | {1'b0, addr[6:0]}, 1'b0);
          bump_tail(17'd0, 1'b1);
        end
      end
      CMD_CLEAR: begin
        add_byte(CLEAR_DISPLAY, 1'b0);
        bump_tail(T_CLEAR, 1'b1);
      end
      CMD_INIT: begin
        inits_seen++;
        add_write({4'h0, backlight_lit, 3'b000}, T_POWER_UP);
        add_nibble(WAKE_NIBBLE, 1'b0);
        bump_tail(T_WAKE_1ST, 1'b0);
        add_nibble(WAKE_NIBBLE, 1'b0);
        bump_tail(T_WAKE, 1'b0);
        add_nibble(WAKE_NIBBLE, 1'b0);
        bump_tail(T_WAKE, 1'b0);
        add_nibble(FOUR_BIT_NIB, 1'b0);
        bump_tail(T_WAKE, 1'b0);
        add_byte(FUNC_SET, 1'b0);
        add_byte(DISPLAY_OFF, 1'b0);
        add_byte(CLEAR_DISPLAY, 1'b0);
        bump_tail(T_CLEAR, 1'b0);
        add_byte(ENTRY_MODE, 1'b0);
        add_byte(DISPLAY_ON, 1'b0);
        bump_tail(17'd0, 1'b1);
        lcd_ready = 1'b1;
      end
      CMD_BACKLIGHT: begin
        backlight_lit = op.ble;
        add_write({4'h0, backlight_lit, 3'b000}, 17'd0);
        bump_tail(17'd0, 1'b1);
      end
      default: add_refusal(ST_INVALID);
    endcase
  endtask

  function automatic lcd_op_t make_op(input logic [2:0] cmd, input logic [7:0] value,
                                      input logic [7:0] col, input logic [1:0] row,
                                      input logic ble);
    lcd_op_t op;
    op.cmd   = cmd;
    op.value = value;
    op.col   = col;
    op.row   = row;
    op.ble   = ble;
    return op;
  endfunction

  function automatic lcd_op_t random_op();
    lcd_op_t op;
    int r;
    op.value = 8'($urandom_range(0, 255));
    op.col   = 8'($urandom_range(0, 255));
    op.row   = 2'($urandom_range(0, 3));
    op.ble   = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 20) op.cmd = CMD_INSTR;
    else if (r < 50) op.cmd = CMD_CHAR;
    else if (r < 72) op.cmd = CMD_CURSOR;
    else if (r < 80) op.cmd = CMD_CLEAR;
    else if (r < 84) op.cmd = CMD_INIT;
    else if (r < 93) op.cmd = CMD_BACKLIGHT;
    else op.cmd = ($urandom_range(0, 1) != 0) ? CMD_UNKNOWN_LO : CMD_UNKNOWN_HI;
    // keep most cursor moves on the screen
    if (op.cmd == CMD_CURSOR && $urandom_range(0, 3) != 0) begin
      op.col = 8'($urandom_range(0, COLUMNS - 1));
      op.row = 2'($urandom_range(0, ROWS - 1));
    end
    return op;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sender: hold the beat while stalled, otherwise advance
  always @(posedge clk) begin
    lcd_op_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        predict_port_writes(make_op(in_cmd, in_value, in_col, in_row, in_backlight_enable));
        beats_in <= beats_in + 1;
      end
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (op_q.size() != 0) begin
        nxt = op_q.pop_front();
        in_cmd              <= nxt.cmd;
        in_value            <= nxt.value;
        in_col              <= nxt.col;
        in_row              <= nxt.row;
        in_backlight_enable <= nxt.ble;
        in_valid            <= 1'b1;
        gap_left            <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold to back the block up
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (!long_hold_done && beats_in >= 40) begin
      out_stall      <= 1'b1;
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (calm || r < 65) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        hold_left <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    port_write_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (write_q.size() == 0) begin
        $display("%0t: unexpected port write byte=%h wait=%0d status=%0d last=%0b",
                 $time, out_port_byte, out_wait_us, out_status, out_last);
        fault_count++;
      end else begin
        exp_w = write_q.pop_front();
        writes_checked++;
        if (out_port_valid !== exp_w.port_valid) begin
          $display("%0t: port_valid expected %0b actual %0b",
                   $time, exp_w.port_valid, out_port_valid);
          fault_count++;
        end
        if (out_port_byte !== exp_w.port_byte) begin
          $display("%0t: port_byte expected %h actual %h",
                   $time, exp_w.port_byte, out_port_byte);
          fault_count++;
        end
        if (out_wait_us !== exp_w.wait_us) begin
          $display("%0t: wait_us expected %0d actual %0d",
                   $time, exp_w.wait_us, out_wait_us);
          fault_count++;
        end
        if (out_status !== exp_w.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, exp_w.status, out_status);
          fault_count++;
        end
        if (out_last !== exp_w.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_w.last, out_last);
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d port writes outstanding", $time, write_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    // before initialise: refusals, raw instructions, cursor edges, clear, backlight
    op_q.push_back(make_op(CMD_CHAR, 8'h41, 8'h00, 2'd0, 1'b0));
    op_q.push_back(make_op(CMD_INSTR, 8'h00, 8'h00, 2'd0, 1'b0));
    op_q.push_back(make_op(CMD_INSTR, 8'hFF, 8'hFF, 2'd3, 1'b1));
    op_q.push_back(make_op(CMD_CURSOR, 8'h00, 8'h00, 2'd0, 1'b0));
    op_q.push_back(make_op(CMD_CURSOR, 8'h00, 8'(COLUMNS - 1), 2'(ROWS - 1), 1'b0));
    op_q.push_back(make_op(CMD_CURSOR, 8'h00, 8'(COLUMNS), 2'd0, 1'b0));
    op_q.push_back(make_op(CMD_CURSOR, 8'h00, 8'hFF, 2'd0, 1'b0));
    op_q.push_back(make_op(CMD_CURSOR, 8'h00, 8'h00, 2'(ROWS), 1'b0));
    op_q.push_back(make_op(CMD_CURSOR, 8'h00, 8'h00, 2'd3, 1'b0));
    op_q.push_back(make_op(CMD_CLEAR, 8'h00, 8'h00, 2'd0, 1'b0));
    op_q.push_back(make_op(CMD_UNKNOWN_LO, 8'hFF, 8'hFF, 2'd3, 1'b1));
    op_q.push_back(make_op(CMD_UNKNOWN_HI, 8'h00, 8'h00, 2'd0, 1'b0));
    op_q.push_back(make_op(CMD_BACKLIGHT, 8'h00, 8'h00, 2'd0, 1'b0));
    op_q.push_back(make_op(CMD_INIT, 8'h00, 8'h00, 2'd0, 1'b0));
    op_q.push_back(make_op(CMD_CHAR, 8'h00, 8'h00, 2'd0, 1'b0));
    op_q.push_back(make_op(CMD_BACKLIGHT, 8'h00, 8'h00, 2'd0, 1'b1));
    op_q.push_back(make_op(CMD_INIT, 8'hFF, 8'hFF, 2'd3, 1'b0));
    op_q.push_back(make_op(CMD_CHAR, 8'hFF, 8'h00, 2'd0, 1'b0));
    op_q.push_back(make_op(CMD_CHAR, 8'hA5, 8'h00, 2'd0, 1'b0));
    op_q.push_back(make_op(CMD_CURSOR, 8'h00, 8'(COLUMNS - 1), 2'd0, 1'b0));
    op_q.push_back(make_op(CMD_CURSOR, 8'h00, 8'h00, 2'(ROWS - 1), 1'b0));
    op_q.push_back(make_op(CMD_CLEAR, 8'hFF, 8'hFF, 2'd3, 1'b1));
    for (int i = 0; i < RANDOM_OPS; i++) op_q.push_back(random_op());

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (op_q.size() != 0 || in_valid || write_q.size() != 0) @(negedge clk);
    repeat (60) @(posedge clk);

    $display("Ran %0d operations: %0d initialise, %0d characters, %0d cursor moves, %0d refused",
             beats_in, inits_seen, chars_seen, cursors_seen, refusals_seen);
    $display("Checked %0d port writes, %0d mismatches", writes_checked, fault_count);
    if (fault_count == 0 && write_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/clnps_pkg.sv
src/char_lcd_nibble_port_sequencer.sv
bench/char_lcd_nibble_port_sequencer_test.sv
